@@ hw/rtl/fmv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_pkg: shared types and constants for face momentum to velocity
// Payload words, boundary kinds, register indexes and divider stage word.
// ----------------------------------------------------------------------------
package fmv_pkg;

	localparam int DATA_W  = 32;
	localparam int VFRAC_W = 16;
	localparam int FSUM_W  = VFRAC_W + 1;
	localparam int DEN_W   = DATA_W + FSUM_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_EB_ENABLED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BC_X_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BC_X_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BC_Y_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BC_Y_HIGH  = 3'd4;

	localparam logic [1:0] BC_OTHER   = 2'd0;
	localparam logic [1:0] BC_EXT_DIR = 2'd1;
	localparam logic [1:0] BC_UPWIND  = 2'd2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;

	typedef struct packed {
		logic [1:0]               axis;
		logic                     at_low_edge;
		logic                     at_high_edge;
		logic signed [DATA_W-1:0] momentum;
		logic [DATA_W-1:0]        density_minus;
		logic [DATA_W-1:0]        density_plus;
		logic [VFRAC_W-1:0]       vfrac_minus;
		logic [VFRAC_W-1:0]       vfrac_plus;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] velocity;
		logic                     written;
		logic                     divide_fault;
	} out_t;

	// per-item control that rides along the divider
	typedef struct packed {
		logic written;
		logic neg;
		logic mag_zero;
		logic den_zero;
		logic ovf;
	} ctl_t;

	typedef struct packed {
		logic [DEN_W-1:0]  rem;
		logic [DEN_W-1:0]  den;
		logic [DATA_W-1:0] nlo;
		logic [DATA_W-1:0] quo;
		ctl_t              ctl;
	} div_t;

endpackage

@@ hw/rtl/fmv_div_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_div_stage: one restoring division step with its pipeline register
// Shift in one numerator bit, subtract the divisor when it fits.
// ----------------------------------------------------------------------------
module fmv_div_stage (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_v,
	input  fmv_pkg::div_t in_d,
	output logic         out_v,
	output fmv_pkg::div_t out_d
);
	import fmv_pkg::*;

	logic [DEN_W:0] r2;
	logic [DEN_W:0] diff;
	logic           ge;
	div_t           nxt;

	always_comb begin
		r2   = {in_d.rem, in_d.nlo[DATA_W-1]};
		diff = r2 - {1'b0, in_d.den};
		ge   = (r2 >= {1'b0, in_d.den});
		nxt      = in_d;
		nxt.rem  = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
		nxt.nlo  = {in_d.nlo[DATA_W-2:0], 1'b0};
		nxt.quo  = {in_d.quo[DATA_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d <= nxt;
		end
	end

endmodule

@@ hw/rtl/face_momentum_to_velocity.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_momentum_to_velocity: staggered-grid face velocity from momentum
// Pipeline: three front stages, one divider stage per quotient bit, one output register.
// Throughput: one face word per cycle while the output is not stalled; every stage is fully pipelined.
// Stages with a bubble absorb a stalled output, so input keeps flowing.
// Reset (arst_n low): all stage valids clear, config registers return to zero.
// ----------------------------------------------------------------------------
module face_momentum_to_velocity #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  fmv_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output fmv_pkg::out_t                   out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fmv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fmv_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fmv_pkg::*;

	// numerator: magnitude * fraction sum, then scaled by 2^FRAC_BITS
	localparam int NUM_W = DATA_W + FSUM_W + FRAC_BITS;
	localparam int HI_W  = NUM_W - DATA_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	localparam logic [1:0] M_PLAIN = 2'd0;
	localparam logic [1:0] M_EB    = 2'd1;
	localparam logic [1:0] M_LO    = 2'd2;
	localparam logic [1:0] M_HI    = 2'd3;

	localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	// ---------------- configuration registers ----------------
	logic       eb_enabled_q;
	logic [1:0] bc_x_low_q, bc_x_high_q, bc_y_low_q, bc_y_high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eb_enabled_q <= 1'b0;
			bc_x_low_q   <= BC_OTHER;
			bc_x_high_q  <= BC_OTHER;
			bc_y_low_q   <= BC_OTHER;
			bc_y_high_q  <= BC_OTHER;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EB_ENABLED: eb_enabled_q <= cfg_data[0];
				CFG_BC_X_LOW:   bc_x_low_q   <= cfg_data;
				CFG_BC_X_HIGH:  bc_x_high_q  <= cfg_data;
				CFG_BC_Y_LOW:   bc_y_low_q   <= cfg_data;
				CFG_BC_Y_HIGH:  bc_y_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- handshake: bubble-collapsing ready chain ----------------
	// A stage loads when it is empty or its successor loads.
	logic          v_s1, v_s2, v_s3;
	logic [DATA_W-1:0] dv;
	logic          rdy_s1, rdy_s2, rdy_s3, rdy_out;
	logic [DATA_W-1:0] rdy_d;
	div_t          dd [DATA_W];

	assign rdy_out = !out_valid || !out_stall;
	assign rdy_d[DATA_W-1] = !dv[DATA_W-1] || rdy_out;
	for (genvar k = 0; k < DATA_W - 1; k++) begin : g_rdy
		assign rdy_d[k] = !dv[k] || rdy_d[k+1];
	end
	assign rdy_s3   = !v_s3 || rdy_d[0];
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// ---------------- stage 1: decode rule, magnitude, products ----------------
	logic              neg_c, zero_c, sel_lo_c, sel_hi_c, wr_c;
	logic [1:0]        bc_lo_c, bc_hi_c, mode_c;
	logic [DATA_W-1:0] mag_c;
	logic [FSUM_W-1:0] fsum_c;

	always_comb begin
		neg_c  = in_data.momentum[DATA_W-1];
		zero_c = (in_data.momentum == '0);
		// two's complement of the most negative value is its own magnitude
		mag_c  = neg_c ? (~in_data.momentum + 1'b1) : in_data.momentum;
		fsum_c = {1'b0, in_data.vfrac_minus} + {1'b0, in_data.vfrac_plus};
		bc_lo_c = BC_OTHER;
		bc_hi_c = BC_OTHER;
		case (in_data.axis)
			AXIS_X: begin
				bc_lo_c = bc_x_low_q;
				bc_hi_c = bc_x_high_q;
			end
			AXIS_Y: begin
				bc_lo_c = bc_y_low_q;
				bc_hi_c = bc_y_high_q;
			end
			default: ;
		endcase
		// low upwind: inflow when momentum >= 0; high upwind: when <= 0
		sel_lo_c = in_data.at_low_edge &&
			(bc_lo_c == BC_EXT_DIR || (bc_lo_c == BC_UPWIND && !neg_c));
		sel_hi_c = in_data.at_high_edge &&
			(bc_hi_c == BC_EXT_DIR || (bc_hi_c == BC_UPWIND && (neg_c || zero_c)));
		// high edge rule is checked first, so it wins
		if (sel_hi_c)          mode_c = M_HI;
		else if (sel_lo_c)     mode_c = M_LO;
		else if (eb_enabled_q) mode_c = M_EB;
		else                   mode_c = M_PLAIN;
		wr_c = sel_lo_c || sel_hi_c || !eb_enabled_q || (fsum_c != '0);
	end

	logic [1:0]                mode_s1;
	logic                      neg_s1, wr_s1;
	logic [DATA_W-1:0]         mag_s1, dm_s1, dp_s1;
	logic [DATA_W+VFRAC_W-1:0] pm_s1, pp_s1;
	logic [DATA_W+FSUM_W-1:0]  pn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			mode_s1 <= mode_c;
			neg_s1  <= neg_c;
			wr_s1   <= wr_c;
			mag_s1  <= mag_c;
			dm_s1   <= in_data.density_minus;
			dp_s1   <= in_data.density_plus;
			pm_s1   <= in_data.vfrac_minus * in_data.density_minus;
			pp_s1   <= in_data.vfrac_plus * in_data.density_plus;
			pn_s1   <= mag_c * fsum_c;
		end
	end

	// ---------------- stage 2: form numerator and divisor ----------------
	logic [NUM_W-1:0] num_c;
	logic [DEN_W-1:0] den_c;

	always_comb begin
		case (mode_s1)
			M_PLAIN: begin
				num_c = NUM_W'(mag_s1) << (FRAC_BITS + 1);
				den_c = DEN_W'(dm_s1) + DEN_W'(dp_s1);
			end
			M_EB: begin
				num_c = NUM_W'(pn_s1) << FRAC_BITS;
				den_c = DEN_W'(pm_s1) + DEN_W'(pp_s1);
			end
			M_LO: begin
				num_c = NUM_W'(mag_s1) << FRAC_BITS;
				den_c = DEN_W'(dm_s1);
			end
			default: begin
				num_c = NUM_W'(mag_s1) << FRAC_BITS;
				den_c = DEN_W'(dp_s1);
			end
		endcase
	end

	logic [NUM_W-1:0]  num_s2;
	logic [DEN_W-1:0]  den_s2;
	logic              neg_s2, wr_s2, mzero_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			num_s2   <= num_c;
			den_s2   <= den_c;
			neg_s2   <= neg_s1;
			wr_s2    <= wr_s1;
			mzero_s2 <= (mag_s1 == '0);
		end
	end

	// ---------------- stage 3: zero divisor and overflow check ----------------
	// Quotient overflows DATA_W bits exactly when the upper numerator part
	// already reaches the divisor; otherwise that part is the first remainder.
	logic [CMP_W-1:0] nhi_c, dcmp_c;
	div_t             d3_c, d_s3;

	always_comb begin
		nhi_c  = CMP_W'(num_s2[NUM_W-1:DATA_W]);
		dcmp_c = CMP_W'(den_s2);
		d3_c.rem          = DEN_W'(nhi_c);
		d3_c.den          = den_s2;
		d3_c.nlo          = num_s2[DATA_W-1:0];
		d3_c.quo          = '0;
		d3_c.ctl.written  = wr_s2;
		d3_c.ctl.neg      = neg_s2;
		d3_c.ctl.mag_zero = mzero_s2;
		d3_c.ctl.den_zero = (den_s2 == '0);
		d3_c.ctl.ovf      = (nhi_c >= dcmp_c);
		// keep the divider remainder bounded when the check already decided
		if (d3_c.ctl.ovf) begin
			d3_c.rem = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			d_s3 <= d3_c;
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	fmv_div_stage u_div_first (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (rdy_d[0]),
		.in_v  (v_s3),
		.in_d  (d_s3),
		.out_v (dv[0]),
		.out_d (dd[0])
	);

	for (genvar k = 1; k < DATA_W; k++) begin : g_div
		fmv_div_stage u_div (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (rdy_d[k]),
			.in_v  (dv[k-1]),
			.in_d  (dd[k-1]),
			.out_v (dv[k]),
			.out_d (dd[k])
		);
	end

	// ---------------- output: sign, saturation, fault ----------------
	div_t fin;
	out_t res_c;
	out_t out_q;

	always_comb begin
		fin = dd[DATA_W-1];
		res_c.written      = fin.ctl.written;
		res_c.divide_fault = 1'b0;
		res_c.velocity     = '0;
		if (!fin.ctl.written) begin
			// hold the face: result is all zero
			res_c.velocity = '0;
		end else if (fin.ctl.den_zero) begin
			res_c.divide_fault = 1'b1;
			if (fin.ctl.mag_zero)  res_c.velocity = '0;
			else if (fin.ctl.neg)  res_c.velocity = MIN_NEG;
			else                   res_c.velocity = MAX_POS;
		end else if (fin.ctl.ovf) begin
			res_c.velocity = fin.ctl.neg ? MIN_NEG : MAX_POS;
		end else if (!fin.ctl.neg) begin
			res_c.velocity = (fin.quo > MAX_POS) ? MAX_POS : fin.quo;
		end else begin
			res_c.velocity = (fin.quo > MIN_NEG) ? MIN_NEG : (~fin.quo + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rdy_out) begin
			out_valid <= dv[DATA_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			out_q <= res_c;
		end
	end

	assign out_data = out_q;

`ifndef ASSERT_OFF
	// an unwritten face carries neither velocity nor fault
	a_unwritten_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.written |-> out_data.velocity == '0 && !out_data.divide_fault)
		else $error("unwritten face with nonzero payload");

	// a fault only comes from a division that was actually performed
	a_fault_written: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_fault |-> out_data.written)
		else $error("divide fault on unwritten face");

	// input backs up only when all three front stages are occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && v_s3)
		else $error("input stalled with a bubble at the pipeline head");

	// a zero divisor never reaches the output as an overflow-free quotient
	a_fault_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_fault && out_data.velocity != '0 |->
		out_data.velocity == MAX_POS || out_data.velocity == MIN_NEG)
		else $error("divide fault without saturated velocity");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for face_momentum_to_velocity
// A table of directed faces with some hand-typed results is applied first.
// Random faces follow under several register settings and idling mixes.
// Every result is checked in order, against its hand-typed value or a local velocity predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import fmv_pkg::*;

	// Lower bound on the pipeline depth; DRAIN adds margin on top of it.
	localparam int LATENCY = DATA_W + 3;
	localparam int DRAIN   = LATENCY + 20;
	localparam int FRAC_BITS_TB = 16;
	localparam logic [DATA_W-1:0] VMAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] VMIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t  in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	face_momentum_to_velocity dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Run limit: far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("[face_momentum_to_velocity] ERROR");
		$finish;
	end

	// Shadow copy of the registers, indexed by register index.
	logic [1:0] shadow_reg [0:4];
	out_t velocity_q [$];
	int   fail_count = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_off_len = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	// Truncating divide with saturation; flag a zero divisor.
	function automatic logic [DATA_W-1:0] sat_quot(input logic neg, input logic [127:0] num,
		input logic [127:0] den, output logic fault);
		logic [127:0] q;
		fault = 1'b0;
		if (den == 0) begin
			fault = 1'b1;
			if (num == 0) return '0;
			return neg ? VMIN : VMAX;
		end
		q = num / den;
		if (!neg) return (q > VMAX) ? VMAX : q[DATA_W-1:0];
		return (q > {96'd0, VMIN}) ? VMIN : -q[DATA_W-1:0];
	endfunction

	// Velocity of one face under the current shadow registers.
	function automatic out_t face_velocity(input in_t f);
		out_t r;
		logic neg, flt;
		logic [DATA_W-1:0] mag;
		logic [127:0] num, den, fsum;
		logic [1:0] bc_lo, bc_hi;
		r = '0;
		flt = 1'b0;
		neg = f.momentum[DATA_W-1];
		mag = neg ? -f.momentum : f.momentum;
		bc_lo = BC_OTHER;
		bc_hi = BC_OTHER;
		if (shadow_reg[CFG_EB_ENABLED][0] == 1'b0) begin
			num = {96'd0, mag} << (FRAC_BITS_TB + 1);
			den = f.density_minus + f.density_plus;
			r.velocity = sat_quot(neg, num, den, flt);
			r.written = 1'b1;
		end else if (f.vfrac_minus + f.vfrac_plus != 0) begin
			fsum = f.vfrac_minus + f.vfrac_plus;
			num = ({96'd0, mag} * fsum) << FRAC_BITS_TB;
			den = 128'(f.vfrac_minus) * f.density_minus + 128'(f.vfrac_plus) * f.density_plus;
			r.velocity = sat_quot(neg, num, den, flt);
			r.written = 1'b1;
		end
		if (f.axis == AXIS_X) begin
			bc_lo = shadow_reg[CFG_BC_X_LOW];
			bc_hi = shadow_reg[CFG_BC_X_HIGH];
		end else if (f.axis == AXIS_Y) begin
			bc_lo = shadow_reg[CFG_BC_Y_LOW];
			bc_hi = shadow_reg[CFG_BC_Y_HIGH];
		end
		// Low edge first, high edge may then overwrite.
		if (f.at_low_edge && (bc_lo == BC_EXT_DIR || (bc_lo == BC_UPWIND && !neg))) begin
			r.velocity = sat_quot(neg, {96'd0, mag} << FRAC_BITS_TB,
				{96'd0, f.density_minus}, flt);
			r.written = 1'b1;
		end
		if (f.at_high_edge && (bc_hi == BC_EXT_DIR ||
				(bc_hi == BC_UPWIND && (neg || f.momentum == 0)))) begin
			r.velocity = sat_quot(neg, {96'd0, mag} << FRAC_BITS_TB,
				{96'd0, f.density_plus}, flt);
			r.written = 1'b1;
		end
		r.divide_fault = r.written ? flt : 1'b0;
		if (!r.written) r.velocity = '0;
		return r;
	endfunction

	// Receiver: random stall, plus one long hold-off counted here.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_off_len <= 300;
			out_stall <= 1'b1;
		end else if (hold_off_len > 0) begin
			out_stall <= 1'b1;
			hold_off_len <= hold_off_len - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check every accepted result against the oldest expectation.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (velocity_q.size() == 0) begin
				$display("%0t: unexpected word %h", $time, out_data);
				fail_count++;
			end else begin
				want = velocity_q.pop_front();
				if (out_data.velocity !== want.velocity) begin
					$display("%0t: velocity expected %h actual %h", $time,
						want.velocity, out_data.velocity);
					fail_count++;
				end
				if (out_data.written !== want.written) begin
					$display("%0t: written expected %b actual %b", $time,
						want.written, out_data.written);
					fail_count++;
				end
				if (out_data.divide_fault !== want.divide_fault) begin
					$display("%0t: divide_fault expected %b actual %b", $time,
						want.divide_fault, out_data.divide_fault);
					fail_count++;
				end
			end
		end
	end

	// Offer one face word, with random idle cycles ahead; hold until taken.
	// Valid stays high after the word is taken; an idle in the next call or a drain drops it.
	task automatic send_face(input in_t f, input bit typed, input out_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= f;
		do @(posedge clk); while (in_stall);
		velocity_q.push_back(typed ? want : face_velocity(f));
	endtask

	// Drain: drop valid, wait for every expected word, then wait out DRAIN.
	task automatic settle();
		in_valid <= 1'b0;
		while (velocity_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		shadow_reg[idx] = val;
	endtask

	task automatic load_regs(input logic eb, input logic [1:0] xl, input logic [1:0] xh,
		input logic [1:0] yl, input logic [1:0] yh);
		settle();
		write_reg(CFG_EB_ENABLED, {1'b0, eb});
		write_reg(CFG_BC_X_LOW, xl);
		write_reg(CFG_BC_X_HIGH, xh);
		write_reg(CFG_BC_Y_LOW, yl);
		write_reg(CFG_BC_Y_HIGH, yh);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_t random_face();
		in_t f;
		f.axis = 2'($urandom_range(3));
		f.at_low_edge = 1'($urandom_range(1));
		f.at_high_edge = 1'($urandom_range(1));
		case ($urandom_range(9))
			0: f.momentum = VMIN;
			1: f.momentum = VMAX;
			2: f.momentum = 0;
			3, 4: f.momentum = $signed(32'($urandom_range(32'h0004_0000))) - 32'sh2_0000;
			default: f.momentum = $urandom;
		endcase
		f.density_minus = ($urandom_range(9) == 0) ? 32'd0 :
			($urandom_range(2) == 0) ? 32'($urandom) : 32'($urandom_range(32'h0008_0000));
		f.density_plus = ($urandom_range(9) == 0) ? 32'd0 :
			($urandom_range(2) == 0) ? 32'($urandom) : 32'($urandom_range(32'h0008_0000));
		case ($urandom_range(7))
			0: f.vfrac_minus = 16'd0;
			1: f.vfrac_minus = 16'd32768;
			2: f.vfrac_minus = 16'($urandom);
			default: f.vfrac_minus = 16'($urandom_range(32768));
		endcase
		case ($urandom_range(7))
			0: f.vfrac_plus = 16'd0;
			1: f.vfrac_plus = 16'd32768;
			2: f.vfrac_plus = 16'($urandom);
			default: f.vfrac_plus = 16'($urandom_range(32768));
		endcase
		return f;
	endfunction

	// Directed table; cfg_set of -1 keeps the current registers.
	typedef struct {
		int   cfg_set;
		in_t  face;
		bit   typed;
		out_t want;
	} face_row_t;

	face_row_t face_rows [20];
	logic [1:0] cfg_sets [4][5];

	initial begin
		in_t  f;
		out_t none;
		none = '0;
		for (int i = 0; i < 5; i++) shadow_reg[i] = 2'd0;
		cfg_sets = '{'{0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0}, '{0, 1, 2, 2, 1}, '{1, 3, 3, 3, 3}};
		// plain interior after reset
		face_rows[0] = '{-1, '{AXIS_X, 0, 0, 32'sh1_0000, 32'h1_0000, 32'h1_0000, 16'd0, 16'd0},
			1, '{32'sh1_0000, 1, 0}};
		face_rows[1] = '{-1, '{AXIS_Y, 0, 0, 32'sh5, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF},
			1, '{VMAX, 1, 1}};
		face_rows[2] = '{-1, '{AXIS_X, 1, 1, -32'sh5, 32'h0, 32'h0, 16'd0, 16'd0},
			1, '{VMIN, 1, 1}};
		face_rows[3] = '{-1, '{2'd2, 0, 0, 32'sh0, 32'h0, 32'h0, 16'd0, 16'd0},
			1, '{32'sh0, 1, 1}};
		face_rows[4] = '{-1, '{AXIS_X, 0, 0, VMAX, 32'h1, 32'h1, 16'd0, 16'd0},
			1, '{VMAX, 1, 0}};
		face_rows[5] = '{-1, '{AXIS_Y, 1, 0, VMIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1,
			16'd1}, 0, none};
		face_rows[6] = '{-1, '{2'd3, 1, 1, 32'sh1234_5678, 32'h3_0000, 32'h7_0000, 16'd9,
			16'd8}, 0, none};
		// weighted-density mode
		face_rows[7] = '{1, '{AXIS_X, 0, 0, 32'sh7777, 32'h1_0000, 32'h1_0000, 16'd0, 16'd0},
			1, '{32'sh0, 0, 0}};
		face_rows[8] = '{-1, '{AXIS_X, 0, 0, 32'sh1_0000, 32'h1_0000, 32'h1_0000, 16'd32768,
			16'd32768}, 1, '{32'sh1_0000, 1, 0}};
		face_rows[9] = '{-1, '{AXIS_Y, 0, 0, -32'sh3_4567, 32'h2_1000, 32'hFFFF_FFFF, 16'hFFFF,
			16'hFFFF}, 0, none};
		face_rows[10] = '{-1, '{2'd2, 0, 0, 32'sh4_0000, 32'h0, 32'h5_0000, 16'd32768, 16'd0},
			1, '{VMAX, 1, 1}};
		// edge overrides: x ext_dir/upwind, y upwind/ext_dir
		face_rows[11] = '{2, '{AXIS_X, 1, 0, 32'sh1_0000, 32'h2_0000, 32'h9_0000, 16'd0,
			16'd0}, 1, '{32'sh8000, 1, 0}};
		face_rows[12] = '{-1, '{AXIS_X, 0, 1, 32'sh2_0000, 32'h2_0000, 32'h3_0000, 16'd0,
			16'd0}, 0, none};
		face_rows[13] = '{-1, '{AXIS_X, 0, 1, -32'sh2_0000, 32'h2_0000, 32'h3_0000, 16'd0,
			16'd0}, 0, none};
		face_rows[14] = '{-1, '{AXIS_X, 1, 1, 32'sh0, 32'h0, 32'h0, 16'd0, 16'd0}, 0, none};
		face_rows[15] = '{-1, '{AXIS_Y, 1, 0, -32'sh2_0000, 32'h4_0000, 32'h3_0000, 16'd0,
			16'd0}, 0, none};
		face_rows[16] = '{-1, '{AXIS_Y, 0, 1, 32'sh2_0000, 32'h4_0000, 32'h0, 16'd0, 16'd0},
			1, '{VMAX, 1, 1}};
		face_rows[17] = '{-1, '{2'd2, 1, 1, 32'sh2_0000, 32'h0, 32'h0, 16'd0, 16'd0}, 0, none};
		// weighted mode, boundary code 3 gives no override
		face_rows[18] = '{3, '{AXIS_X, 1, 1, 32'sh2_0000, 32'h1_0000, 32'h1_0000, 16'd0,
			16'd0}, 1, '{32'sh0, 0, 0}};
		face_rows[19] = '{-1, '{AXIS_Y, 1, 0, 32'sh9_0000, 32'h3_0000, 32'h1_0000, 16'd100,
			16'd3}, 0, none};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table at full rate.
		foreach (face_rows[i]) begin
			if (face_rows[i].cfg_set >= 0) begin
				load_regs(cfg_sets[face_rows[i].cfg_set][0][0], cfg_sets[face_rows[i].cfg_set][1],
					cfg_sets[face_rows[i].cfg_set][2], cfg_sets[face_rows[i].cfg_set][3],
					cfg_sets[face_rows[i].cfg_set][4]);
			end
			send_face(face_rows[i].face, face_rows[i].typed, face_rows[i].want);
		end

		// Random faces: three idling mixes, several register settings each.
		for (int mix = 0; mix < 3; mix++) begin
			send_idle_pct = (mix == 0) ? 36 : (mix == 1) ? 51 : 0;
			recv_idle_pct = (mix == 0) ? 51 : (mix == 1) ? 36 : 0;
			for (int blk = 0; blk < 5; blk++) begin
				if (blk == 0) load_regs(mix != 0, BC_EXT_DIR, BC_UPWIND, BC_UPWIND, BC_EXT_DIR);
				else load_regs(1'($urandom_range(1)), 2'($urandom_range(3)),
					2'($urandom_range(3)), 2'($urandom_range(3)), 2'($urandom_range(3)));
				for (int n = 0; n < 100; n++) begin
					// long receiver hold-off while faces keep coming
					if (mix == 2 && blk == 1 && n == 10) hold_req <= 1'b1;
					// once, pause the sender until the pipeline has drained
					if (mix == 2 && blk == 2 && n == 50) begin
						in_valid <= 1'b0;
						while (velocity_q.size() != 0) @(posedge clk);
					end
					f = random_face();
					send_face(f, 0, none);
				end
			end
		end

		settle();
		if (fail_count == 0) begin
			$display("[face_momentum_to_velocity] OK");
		end else begin
			$display("[face_momentum_to_velocity] ERROR");
		end
		$finish;
	end
endmodule
